// ===== rtl/pcm_liquid_fraction_update_macros.svh =====
// assertion macros for the liquid fraction update block
`ifndef PCM_LIQUID_FRACTION_UPDATE_MACROS_SVH
`define PCM_LIQUID_FRACTION_UPDATE_MACROS_SVH

// condition implies expression in the same cycle
`define PCMLF_ASSERT_IMP(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("pcmlf same-cycle check failed");

// condition implies expression in the next cycle
`define PCMLF_ASSERT_NXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("pcmlf next-cycle check failed");

`endif

// ===== rtl/pcmlf_pkg.sv =====
// shared types, constants and the erf table for the liquid fraction update
package pcmlf_pkg;

  localparam int ERF_DEPTH    = 256;
  localparam int ERF_SUBSTEPS = 16;
  localparam int CFG_AW       = 5;

  localparam logic [16:0] FRAC_ONE  = 17'd65536;
  localparam logic [63:0] ONE_Q60   = 64'd1 << 60;
  localparam logic [63:0] ERF_SCALE = 64'd3230901080;

  // register indexes
  localparam logic [2:0] REG_MELT_MID    = 3'd0;
  localparam logic [2:0] REG_SOLID_SPR   = 3'd1;
  localparam logic [2:0] REG_LIQUID_SPR  = 3'd2;
  localparam logic [2:0] REG_RELAX       = 3'd3;
  localparam logic [2:0] REG_COND_BASE   = 3'd4;
  localparam logic [2:0] REG_COND_SLOPE  = 3'd5;
  localparam logic [2:0] REG_HEAT_BASE   = 3'd6;
  localparam logic [2:0] REG_HEAT_SLOPE  = 3'd7;

  typedef logic [16:0] erf_tab_t [0:ERF_DEPTH];

  // item info carried through the erf position divider
  typedef struct packed {
    logic       mode;
    logic [9:0] idx;
    logic       le0;
    logic       ovf;
  } erf_tag_t;

  // item info carried through the target divider
  typedef struct packed {
    logic       mode;
    logic [9:0] idx;
  } tgt_tag_t;

  // item info carried through the diffusivity divider
  typedef struct packed {
    logic [16:0] fl;
    logic [23:0] k;
    logic [23:0] c;
    logic        sat;
  } dif_tag_t;

  // (a*b) >> 60 in q60
  function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[123:60];
  endfunction

  // step count, its log, and the exp(-t^2) recurrence ratio in q60
  localparam logic [63:0] ERF_N    = 64'(ERF_DEPTH * ERF_SUBSTEPS);
  localparam int          ERF_N_LG = $clog2(ERF_DEPTH * ERF_SUBSTEPS);
  localparam logic [63:0] ERF_Y    = (64'h8000_0000_0000_0000 / (ERF_N * ERF_N)) << 1;
  localparam logic [63:0] ERF_Y2   = mulq(ERF_Y, ERF_Y);
  localparam logic [63:0] ERF_Y3   = mulq(ERF_Y2, ERF_Y);
  localparam logic [63:0] ERF_Y4   = mulq(ERF_Y3, ERF_Y);
  localparam logic [63:0] ERF_R    = ONE_Q60 - ERF_Y + ERF_Y2 / 64'd2 - ERF_Y3 / 64'd6
                                     + ERF_Y4 / 64'd24;
  localparam logic [63:0] ERF_R2   = mulq(ERF_R, ERF_R);

  // erf table by simpson integration of exp(-t^2), built at elaboration
  function automatic erf_tab_t erf_build();
    erf_tab_t    tab;
    logic [63:0] g, q, acc, w32, e, wgt;
    g   = ONE_Q60;
    q   = ERF_R;
    acc = '0;
    tab[0] = '0;
    for (int i = 0; i < ERF_DEPTH; i++) begin
      for (int j = 0; j <= ERF_SUBSTEPS; j++) begin
        if (j == 0 || j == ERF_SUBSTEPS) begin
          wgt = 64'd1;
        end else if ((j & 1) != 0) begin
          wgt = 64'd4;
        end else begin
          wgt = 64'd2;
        end
        acc = acc + wgt * (g >> 16);
        if (j < ERF_SUBSTEPS) begin
          g = mulq(g, q);
          q = mulq(q, ERF_R2);
        end
      end
      w32 = (acc >> ERF_N_LG) >> 12;
      e   = (w32 * ERF_SCALE + (64'd1 << 46)) >> 47;
      if (e > 64'd65536) begin
        e = 64'd65536;
      end
      tab[i + 1] = e[16:0];
    end
    return tab;
  endfunction

  localparam erf_tab_t ERF_TAB = erf_build();

endpackage

// ===== rtl/pcmlf_ram.sv =====
// generic single-port-write, registered-read ram
module pcmlf_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pcmlf_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with a side tag
module pcmlf_div #(
  parameter int NW = 49,
  parameter int DW = 25,
  parameter int QW = 24,
  parameter int TW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic [TW-1:0] out_tag
);

  logic [QW-1:0] vld_r;
  logic [DW-1:0] rem_r  [0:QW-1];
  logic [QW-1:0] work_r [0:QW-1];
  logic [DW-1:0] den_r  [0:QW-1];
  logic [TW-1:0] tag_r  [0:QW-1];
  logic [DW-1:0] rem_nxt  [0:QW-1];
  logic [QW-1:0] work_nxt [0:QW-1];
  logic [DW-1:0] den_nxt  [0:QW-1];
  logic [TW-1:0] tag_nxt  [0:QW-1];

  for (genvar gs = 0; gs < QW; gs++) begin : g_stage
    logic [DW-1:0] rem_i;
    logic [QW-1:0] work_i;
    logic [DW:0]   rs;
    logic          ge;

    // stage source: ports for the first stage, previous stage otherwise
    if (gs == 0) begin : g_first
      assign rem_i        = DW'(in_num[NW-1:QW]);
      assign work_i       = in_num[QW-1:0];
      assign den_nxt[gs]  = in_den;
      assign tag_nxt[gs]  = in_tag;
    end else begin : g_next
      assign rem_i        = rem_r[gs-1];
      assign work_i       = work_r[gs-1];
      assign den_nxt[gs]  = den_r[gs-1];
      assign tag_nxt[gs]  = tag_r[gs-1];
    end

    // shift in one numerator bit, subtract when it fits
    always_comb begin
      rs = {rem_i, work_i[QW-1]};
      ge = rs >= {1'b0, den_nxt[gs]};
      rem_nxt[gs]  = ge ? DW'(rs - {1'b0, den_nxt[gs]}) : rs[DW-1:0];
      work_nxt[gs] = {work_i[QW-2:0], ge};
    end
  end

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-2:0], in_vld};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QW; s++) begin
        rem_r[s]  <= rem_nxt[s];
        work_r[s] <= work_nxt[s];
        den_r[s]  <= den_nxt[s];
        tag_r[s]  <= tag_nxt[s];
      end
    end
  end

  assign out_vld = vld_r[QW-1];
  assign out_quo = work_r[QW-1];
  assign out_tag = tag_r[QW-1];

endmodule

// ===== rtl/pcm_liquid_fraction_update.sv =====
// liquid fraction update with effective conductivity, heat capacity, diffusivity
//
//   port group   direction  handshake          payload
//   in_*         input      in_valid/in_stall  mode, element_index, temperature
//   out_*        output     out_valid/out_stall liquid_fraction, conductivity,
//                                               heat_capacity, diffusivity
//   apb          input      psel/penable       8 registers at 4*i, pready high
//
// one item per cycle sustained while the pipeline advances and the store is not being cleared;
// most of the pipeline is the three bit-per-stage dividers (24, 17, 32 stages).
// after reset the fraction store is cleared element by element with in_stall high.
// out_stall on a held result freezes the whole pipeline; a one-item skid keeps in_stall registered.
`include "pcm_liquid_fraction_update_macros.svh"

module pcm_liquid_fraction_update
  import pcmlf_pkg::*;
#(
  parameter int ELEMENTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [9:0]         in_element_index,
  input  logic signed [23:0] in_temperature,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        out_liquid_fraction,
  output logic [23:0]        out_conductivity,
  output logic [23:0]        out_heat_capacity,
  output logic [31:0]        out_diffusivity,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int ELEM_AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int XW      = (ELEM_AW > 10) ? ELEM_AW : 10;
  localparam logic [16:0]        ELEM_CNT  = 17'(ELEMENTS);
  localparam logic [ELEM_AW-1:0] ELEM_LAST = ELEM_AW'(ELEMENTS - 1);

  // configuration registers
  logic signed [23:0] mid_r;
  logic [22:0]        ss_r, sl_r;
  logic [16:0]        relax_r;
  logic [23:0]        kbase_r;
  logic signed [24:0] kslope_r;
  logic [23:0]        hbase_r;
  logic signed [23:0] hslope_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r    <= '0;
      ss_r     <= 23'd256;
      sl_r     <= 23'd256;
      relax_r  <= 17'd65536;
      kbase_r  <= 24'd65536;
      kslope_r <= '0;
      hbase_r  <= 24'd2000000;
      hslope_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_MELT_MID:   mid_r    <= pwdata[23:0];
        REG_SOLID_SPR:  ss_r     <= pwdata[22:0];
        REG_LIQUID_SPR: sl_r     <= pwdata[22:0];
        REG_RELAX:      relax_r  <= pwdata[16:0];
        REG_COND_BASE:  kbase_r  <= pwdata[23:0];
        REG_COND_SLOPE: kslope_r <= pwdata[24:0];
        REG_HEAT_BASE:  hbase_r  <= pwdata[23:0];
        REG_HEAT_SLOPE: hslope_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      REG_MELT_MID:   prdata = 32'(mid_r);
      REG_SOLID_SPR:  prdata = 32'(ss_r);
      REG_LIQUID_SPR: prdata = 32'(sl_r);
      REG_RELAX:      prdata = 32'(relax_r);
      REG_COND_BASE:  prdata = 32'(kbase_r);
      REG_COND_SLOPE: prdata = 32'(kslope_r);
      REG_HEAT_BASE:  prdata = 32'(hbase_r);
      REG_HEAT_SLOPE: prdata = 32'(hslope_r);
      default:        prdata = '0;
    endcase
  end

  // zero spread acts as one
  logic [22:0] ss_eff, sl_eff;
  logic [23:0] den;
  assign ss_eff = (ss_r == '0) ? 23'd1 : ss_r;
  assign sl_eff = (sl_r == '0) ? 23'd1 : sl_r;
  assign den    = 24'(ss_eff) + 24'(sl_eff);

  // global advance: the pipeline moves unless the held result is stalled
  logic adv, in_acc;
  logic out_valid_r;
  assign adv    = !(out_valid_r && out_stall);
  assign in_acc = in_valid && !in_stall;

  // store clearing pass after reset
  logic               clr_r;
  logic [ELEM_AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == ELEM_LAST) begin
        clr_r <= 1'b0;
      end
    end
  end

  // input skid and first stage
  logic               sk_full_r, sk_mode_r;
  logic [9:0]         sk_idx_r;
  logic [23:0]        sk_temp_r;
  logic               s0_vld_r, s0_mode_r;
  logic [9:0]         s0_idx_r;
  logic [23:0]        s0_temp_r;

  assign in_stall = sk_full_r | clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_full_r <= 1'b0;
      s0_vld_r  <= 1'b0;
    end else if (adv) begin
      sk_full_r <= 1'b0;
      s0_vld_r  <= sk_full_r | in_acc;
    end else if (in_acc) begin
      sk_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_acc) begin
      sk_mode_r <= in_mode;
      sk_idx_r  <= in_element_index;
      sk_temp_r <= in_temperature;
    end
    if (adv) begin
      s0_mode_r <= sk_full_r ? sk_mode_r : in_mode;
      s0_idx_r  <= sk_full_r ? sk_idx_r  : in_element_index;
      s0_temp_r <= sk_full_r ? sk_temp_r : in_temperature;
    end
  end

  // distance from the mid temperature and erf position divider setup
  logic signed [24:0] d;
  logic               le0, ovf;
  logic [24:0]        mag, dv1;
  logic [48:0]        num1;
  erf_tag_t           tag1;

  always_comb begin
    d    = $signed({s0_temp_r[23], s0_temp_r}) - $signed({mid_r[23], mid_r});
    le0  = d[24] | (d == '0);
    mag  = d[24] ? 25'(-d) : 25'(d);
    dv1  = {(le0 ? ss_eff : sl_eff), 2'b00};
    ovf  = mag >= dv1;
    num1 = ovf ? '0 : {mag, 24'b0};
    tag1 = '{mode: s0_mode_r, idx: s0_idx_r, le0: le0, ovf: ovf};
  end

  logic        d1_vld;
  logic [23:0] q1;
  erf_tag_t    d1_tag;

  pcmlf_div #(.NW(49), .DW(25), .QW(24), .TW($bits(erf_tag_t))) u_div_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (s0_vld_r),
    .in_num  (num1),
    .in_den  (dv1),
    .in_tag  (tag1),
    .out_vld (d1_vld),
    .out_quo (q1),
    .out_tag (d1_tag)
  );

  // erf table read
  logic        e1_vld_r;
  logic [16:0] e1_a_r, e1_db_r;
  logic [15:0] e1_frac_r;
  erf_tag_t    e1_tag_r;
  logic [16:0] tab_a, tab_b;

  assign tab_a = ERF_TAB[q1[23:16]];
  assign tab_b = ERF_TAB[9'(q1[23:16]) + 9'd1];

  // interpolation
  logic [33:0] ip;
  logic [16:0] e_val;
  logic        e2_vld_r;
  logic [16:0] e2_e_r;
  erf_tag_t    e2_tag_r;

  always_comb begin
    ip    = 34'(e1_db_r) * 34'(e1_frac_r) + 34'd32768;
    e_val = e1_tag_r.ovf ? FRAC_ONE : 17'(18'(e1_a_r) + ip[33:16]);
  end

  // melt curve numerator
  logic [39:0] m_prod;
  logic        m_vld_r, m_le0_r, m_mode_r;
  logic [39:0] m_prod_r;
  logic [9:0]  m_idx_r;

  always_comb begin
    if (e2_tag_r.le0) begin
      m_prod = 40'(FRAC_ONE - e2_e_r) * 40'(ss_eff);
    end else begin
      m_prod = 40'(e2_e_r) * 40'(sl_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
      e2_vld_r <= 1'b0;
      m_vld_r  <= 1'b0;
    end else if (adv) begin
      e1_vld_r <= d1_vld;
      e2_vld_r <= e1_vld_r;
      m_vld_r  <= e2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_a_r    <= tab_a;
      e1_db_r   <= tab_b - tab_a;
      e1_frac_r <= q1[15:0];
      e1_tag_r  <= d1_tag;
      e2_e_r    <= e_val;
      e2_tag_r  <= e1_tag_r;
      m_prod_r  <= m_prod;
      m_le0_r   <= e2_tag_r.le0;
      m_mode_r  <= e2_tag_r.mode;
      m_idx_r   <= e2_tag_r.idx;
    end
  end

  // target divider
  logic [40:0] num2;
  tgt_tag_t    tag2;
  logic        d2_vld;
  logic [16:0] q2;
  tgt_tag_t    d2_tag;

  assign num2 = 41'(m_prod_r) + (m_le0_r ? 41'd0 : (41'(ss_eff) << 16)) + 41'(den >> 1);
  assign tag2 = '{mode: m_mode_r, idx: m_idx_r};

  pcmlf_div #(.NW(41), .DW(24), .QW(17), .TW($bits(tgt_tag_t))) u_div_tgt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (m_vld_r),
    .in_num  (num2),
    .in_den  (den),
    .in_tag  (tag2),
    .out_vld (d2_vld),
    .out_quo (q2),
    .out_tag (d2_tag)
  );

  // fraction store: read issued at the divider output, data in the update stage
  logic [XW-1:0]      rd_ext, x_ext;
  logic [ELEM_AW-1:0] ram_raddr, ram_waddr, x_addr;
  logic [16:0]        ram_rdata, ram_wdata;
  logic               ram_we;

  assign rd_ext    = XW'(d2_tag.idx);
  assign ram_raddr = rd_ext[ELEM_AW-1:0];

  pcmlf_ram #(.WIDTH(17), .DEPTH(ELEMENTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // update stage: forwarding from the previous write, relaxation in mode 1, clamp
  logic               x_vld_r, x_mode_r;
  logic [16:0]        x_tgt_r;
  logic [9:0]         x_idx_r;
  logic               w_vld_r, w_wr_r;
  logic [16:0]        w_fl_r;
  logic [9:0]         w_idx_r;
  logic               x_inr;
  logic [16:0]        old, fl_x;
  logic signed [17:0] diff;
  logic signed [35:0] rp, rps;
  logic signed [20:0] flx;

  assign x_ext  = XW'(x_idx_r);
  assign x_addr = x_ext[ELEM_AW-1:0];
  assign x_inr  = {7'b0, x_idx_r} < ELEM_CNT;

  always_comb begin
    if (!x_inr) begin
      old = '0;
    end else if (w_wr_r && (w_idx_r == x_idx_r)) begin
      old = w_fl_r;
    end else begin
      old = ram_rdata;
    end
    diff = $signed({1'b0, x_tgt_r}) - $signed({1'b0, old});
    rp   = $signed({1'b0, relax_r}) * diff;
    rps  = rp + 36'sd32768;
    flx  = $signed({4'b0, old}) + $signed({rps[35], rps[35:16]});
    if (!x_mode_r) begin
      fl_x = (x_tgt_r > FRAC_ONE) ? FRAC_ONE : x_tgt_r;
    end else if (flx < 0) begin
      fl_x = '0;
    end else if (flx > $signed({4'b0, FRAC_ONE})) begin
      fl_x = FRAC_ONE;
    end else begin
      fl_x = flx[16:0];
    end
  end

  // write back, or zeros during the clearing pass
  assign ram_we    = clr_r | (adv & x_vld_r & x_inr);
  assign ram_waddr = clr_r ? clr_cnt_r : x_addr;
  assign ram_wdata = clr_r ? 17'd0 : fl_x;

  // property products and sums
  logic               p_vld_r, p2_vld_r;
  logic [16:0]        p_fl_r, p2_fl_r;
  logic signed [42:0] p_kp_r, kps;
  logic signed [41:0] p_hp_r, hps;
  logic signed [26:0] ksum;
  logic signed [25:0] hsum;
  logic [23:0]        k_val, c_val, p2_k_r, p2_c_r;

  always_comb begin
    kps  = p_kp_r + 43'sd32768;
    hps  = p_hp_r + 42'sd32768;
    ksum = $signed({3'b0, kbase_r}) + kps[42:16];
    hsum = $signed({2'b0, hbase_r}) + hps[41:16];
    if (ksum < 0) begin
      k_val = '0;
    end else if (ksum > 27'sd16777215) begin
      k_val = 24'hFFFFFF;
    end else begin
      k_val = ksum[23:0];
    end
    if (hsum < 26'sd1) begin
      c_val = 24'd1;
    end else if (hsum > 26'sd16777215) begin
      c_val = 24'hFFFFFF;
    end else begin
      c_val = hsum[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r  <= 1'b0;
      w_vld_r  <= 1'b0;
      w_wr_r   <= 1'b0;
      p_vld_r  <= 1'b0;
      p2_vld_r <= 1'b0;
    end else if (adv) begin
      x_vld_r  <= d2_vld;
      w_vld_r  <= x_vld_r;
      w_wr_r   <= x_vld_r & x_inr;
      p_vld_r  <= w_vld_r;
      p2_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_tgt_r  <= q2;
      x_mode_r <= d2_tag.mode;
      x_idx_r  <= d2_tag.idx;
      w_fl_r   <= fl_x;
      w_idx_r  <= x_idx_r;
      p_fl_r   <= w_fl_r;
      p_kp_r   <= kslope_r * $signed({1'b0, w_fl_r});
      p_hp_r   <= hslope_r * $signed({1'b0, w_fl_r});
      p2_fl_r  <= p_fl_r;
      p2_k_r   <= k_val;
      p2_c_r   <= c_val;
    end
  end

  // diffusivity divider with saturation detected up front
  logic [47:0] num3;
  logic        sat;
  dif_tag_t    tag3;
  logic        d3_vld;
  logic [31:0] q3;
  dif_tag_t    d3_tag;

  assign num3 = {p2_k_r, 24'b0} + 48'(p2_c_r >> 1);
  assign sat  = 24'(num3[47:32]) >= p2_c_r;
  assign tag3 = '{fl: p2_fl_r, k: p2_k_r, c: p2_c_r, sat: sat};

  pcmlf_div #(.NW(48), .DW(24), .QW(32), .TW($bits(dif_tag_t))) u_div_dif (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (p2_vld_r),
    .in_num  (sat ? 48'd0 : num3),
    .in_den  (p2_c_r),
    .in_tag  (tag3),
    .out_vld (d3_vld),
    .out_quo (q3),
    .out_tag (d3_tag)
  );

  // output register
  logic [16:0] out_fl_r;
  logic [23:0] out_k_r, out_c_r;
  logic [31:0] out_dif_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_fl_r  <= d3_tag.fl;
      out_k_r   <= d3_tag.k;
      out_c_r   <= d3_tag.c;
      out_dif_r <= d3_tag.sat ? 32'hFFFF_FFFF : q3;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_liquid_fraction = out_fl_r;
  assign out_conductivity    = out_k_r;
  assign out_heat_capacity   = out_c_r;
  assign out_diffusivity     = out_dif_r;

  // checks
  `PCMLF_ASSERT_IMP(a_clear_empty, clr_r, !s0_vld_r && !x_vld_r)
  `PCMLF_ASSERT_NXT(a_skid_drains, sk_full_r && adv, s0_vld_r && !sk_full_r)
  `PCMLF_ASSERT_IMP(a_frac_range, out_valid_r, out_fl_r <= FRAC_ONE)
  `PCMLF_ASSERT_IMP(a_write_back, adv && x_vld_r && x_inr, ram_we && ram_waddr == x_addr)

endmodule

// ===== tb/pcm_liquid_fraction_update_tb.sv =====
// testbench for the liquid fraction update block: random and directed items, scoreboard
`timescale 1ns / 100ps

module pcm_liquid_fraction_update_tb;
  import pcmlf_pkg::*;

  typedef struct {
    logic               mode;
    logic [9:0]         idx;
    logic signed [23:0] temp;
  } melt_item_t;

  typedef struct {
    logic [16:0] fl;
    logic [23:0] k;
    logic [23:0] c;
    logic [31:0] dif;
  } props_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_mode = 1'b0;
  logic [9:0]         in_element_index = '0;
  logic signed [23:0] in_temperature = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [16:0]        out_liquid_fraction;
  logic [23:0]        out_conductivity;
  logic [23:0]        out_heat_capacity;
  logic [31:0]        out_diffusivity;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_AW-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  pcm_liquid_fraction_update u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_element_index(in_element_index), .in_temperature(in_temperature),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_liquid_fraction(out_liquid_fraction), .out_conductivity(out_conductivity),
    .out_heat_capacity(out_heat_capacity), .out_diffusivity(out_diffusivity),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // own copy of the registers and the fraction store
  logic signed [23:0] melt_mid = '0;
  logic [22:0]        solid_spr = 23'd256;
  logic [22:0]        liquid_spr = 23'd256;
  logic [16:0]        relax_w = 17'd65536;
  logic [23:0]        k_base = 24'd65536;
  logic signed [24:0] k_slope = '0;
  logic [23:0]        c_base = 24'd2000000;
  logic signed [23:0] c_slope = '0;
  logic [16:0]        fraction_mem [0:1023];
  longint unsigned    erf_q16 [0:256];

  melt_item_t items_to_send [$];
  props_t     props_due [$];
  int         accepted_cnt = 0;
  int         gap_left = 0;
  int         gap_pct = 15;
  int         stall_left = 0;
  int         stall_pct = 15;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  bit         errors = 1'b0;

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL pcm_liquid_fraction_update");
    $finish;
  end

  // (a*b) >> 60 on q60 values
  function automatic longint unsigned q60_mul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // erf by simpson sums of exp(-t^2) from a q60 recurrence
  task automatic make_erf_table();
    longint unsigned n, y, y2, y3, y4, r, r2, g, q, acc, w32, e, wgt;
    n = 4096;
    y = ((64'h8000_0000_0000_0000 / (n * n)) << 1);
    y2 = q60_mul(y, y);
    y3 = q60_mul(y2, y);
    y4 = q60_mul(y3, y);
    r = (64'd1 << 60) - y + y2 / 2 - y3 / 6 + y4 / 24;
    r2 = q60_mul(r, r);
    g = 64'd1 << 60;
    q = r;
    acc = 0;
    erf_q16[0] = 0;
    for (int i = 0; i < 256; i++) begin
      for (int j = 0; j <= 16; j++) begin
        wgt = (j == 0 || j == 16) ? 1 : ((j % 2) ? 4 : 2);
        acc += wgt * (g >> 16);
        if (j < 16) begin
          g = q60_mul(g, q);
          q = q60_mul(q, r2);
        end
      end
      w32 = (acc / n) >> 12;
      e = (w32 * 64'd3230901080 + (64'd1 << 46)) >> 47;
      if (e > 65536) e = 65536;
      erf_q16[i + 1] = e;
    end
  endtask

  // signed erf(d/sigma) in q1.16 by table interpolation
  function automatic longint erf_of(longint d, longint unsigned sigma);
    longint unsigned mag, pos, ix, fr, e;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    pos = ((mag * 256) << 16) / (4 * sigma);
    ix = pos >> 16;
    fr = pos & 64'hFFFF;
    if (ix >= 256) begin
      e = 65536;
    end else begin
      e = erf_q16[ix] + (((erf_q16[ix + 1] - erf_q16[ix]) * fr + 32768) >> 16);
    end
    return (d < 0) ? -longint'(e) : longint'(e);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // new fraction and properties for one element; updates the store
  function automatic props_t update_element(melt_item_t it);
    longint unsigned ss, sl, den, num, alpha;
    longint d, target, old, fl, k, c;
    props_t res;
    ss = (solid_spr == 0) ? 1 : longint'(solid_spr);
    sl = (liquid_spr == 0) ? 1 : longint'(liquid_spr);
    den = ss + sl;
    d = longint'(it.temp) - longint'(melt_mid);
    old = fraction_mem[it.idx];
    if (d <= 0) begin
      num = longint'(65536 + erf_of(d, ss)) * ss;
    end else begin
      num = sl * longint'(erf_of(d, sl)) + 65536 * ss;
    end
    target = (num + den / 2) / den;
    if (it.mode) begin
      fl = old + ((longint'(relax_w) * (target - old) + 32768) >>> 16);
    end else begin
      fl = target;
    end
    fl = clip(fl, 0, 65536);
    fraction_mem[it.idx] = fl[16:0];
    k = clip(longint'(k_base) + ((longint'(k_slope) * fl + 32768) >>> 16), 0, 24'hFFFFFF);
    c = clip(longint'(c_base) + ((longint'(c_slope) * fl + 32768) >>> 16), 1, 24'hFFFFFF);
    alpha = ((longint'(k) << 24) + c / 2) / c;
    if (alpha > 64'hFFFF_FFFF) alpha = 64'hFFFF_FFFF;
    res.fl = fl[16:0];
    res.k = k[23:0];
    res.c = c[23:0];
    res.dif = alpha[31:0];
    return res;
  endfunction

  // input driver: accept, predict, then offer the next item or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        props_due.push_back(update_element('{in_mode, in_element_index, in_temperature}));
        accepted_cnt++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled item as it is
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (items_to_send.size() > 0 && $urandom_range(99) < gap_pct) begin
        gap_left = $urandom_range(0, 14);
        in_valid <= 1'b0;
      end else if (items_to_send.size() > 0) begin
        melt_item_t it;
        it = items_to_send.pop_front();
        in_valid <= 1'b1;
        in_mode <= it.mode;
        in_element_index <= it.idx;
        in_temperature <= it.temp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random bursts plus one long hold-off to fill the pipe
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && accepted_cnt >= 300) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (props_due.size() == 0) begin
        $display("%0t: result with nothing expected, fl %0d", $realtime,
                 out_liquid_fraction);
        errors = 1'b1;
      end else begin
        props_t ex;
        ex = props_due.pop_front();
        if (out_liquid_fraction !== ex.fl) begin
          $display("%0t: liquid_fraction exp %0d got %0d", $realtime, ex.fl,
                   out_liquid_fraction);
          errors = 1'b1;
        end
        if (out_conductivity !== ex.k) begin
          $display("%0t: conductivity exp %0d got %0d", $realtime, ex.k, out_conductivity);
          errors = 1'b1;
        end
        if (out_heat_capacity !== ex.c) begin
          $display("%0t: heat_capacity exp %0d got %0d", $realtime, ex.c, out_heat_capacity);
          errors = 1'b1;
        end
        if (out_diffusivity !== ex.dif) begin
          $display("%0t: diffusivity exp %0d got %0d", $realtime, ex.dif, out_diffusivity);
          errors = 1'b1;
        end
      end
    end
  end

  // register write: setup then access cycle, mirrored into the local copy
  task automatic write_reg(input logic [2:0] r, input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'({r, 2'b00});
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_MELT_MID:   melt_mid = v[23:0];
      REG_SOLID_SPR:  solid_spr = v[22:0];
      REG_LIQUID_SPR: liquid_spr = v[22:0];
      REG_RELAX:      relax_w = v[16:0];
      REG_COND_BASE:  k_base = v[23:0];
      REG_COND_SLOPE: k_slope = v[24:0];
      REG_HEAT_BASE:  c_base = v[23:0];
      default:        c_slope = v[23:0];
    endcase
  endtask

  // wait until nothing is queued, offered or in flight
  task automatic wait_drained();
    wait (items_to_send.size() == 0 && !in_valid && props_due.size() == 0);
    repeat (90) @(posedge clk);
  endtask

  function automatic logic [22:0] pick_spread();
    case ($urandom_range(3))
      0: return 23'($urandom_range(1, 64));
      1: return 23'($urandom_range(1, 4000));
      2: return 23'($urandom_range(1, 100000));
      default: return 23'($urandom);
    endcase
  endfunction

  task automatic random_config();
    write_reg(REG_MELT_MID, $urandom_range(1) ? $urandom : 32'($urandom_range(0, 8000)));
    write_reg(REG_SOLID_SPR, pick_spread());
    write_reg(REG_LIQUID_SPR, pick_spread());
    write_reg(REG_RELAX, $urandom_range(0, 65536));
    write_reg(REG_COND_BASE, $urandom_range(0, 24'hFFFFFF));
    write_reg(REG_COND_SLOPE, $urandom);
    write_reg(REG_HEAT_BASE, $urandom_range(1, 24'hFFFFFF));
    write_reg(REG_HEAT_SLOPE, $urandom);
  endtask

  // mostly temperatures near the melt band on a few elements, some wide
  task automatic queue_random(int n);
    melt_item_t it;
    longint span, t;
    for (int i = 0; i < n; i++) begin
      it.mode = $urandom_range(1);
      it.idx = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
      span = 5 * (longint'(solid_spr) + longint'(liquid_spr)) + 2;
      if ($urandom_range(4) == 0) begin
        it.temp = 24'($urandom);
      end else begin
        t = longint'(melt_mid) + longint'($urandom_range(0, 32'(2 * span))) - span;
        it.temp = 24'(clip(t, -8388608, 8388607));
      end
      items_to_send.push_back(it);
    end
  endtask

  initial begin
    for (int i = 0; i < 1024; i++) fraction_mem[i] = '0;
    make_erf_table();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: temperature extremes, both modes, index extremes
    items_to_send.push_back('{1'b0, 10'd0, 24'sh800000});
    items_to_send.push_back('{1'b0, 10'd1023, 24'sh7FFFFF});
    items_to_send.push_back('{1'b1, 10'd1023, 24'sh000000});
    items_to_send.push_back('{1'b0, 10'd5, 24'sh000000});
    items_to_send.push_back('{1'b0, 10'd6, 24'sh000001});
    items_to_send.push_back('{1'b0, 10'd7, 24'shFFFFFF});
    items_to_send.push_back('{1'b1, 10'd5, 24'sh000100});
    items_to_send.push_back('{1'b1, 10'd0, 24'sh000400});
    items_to_send.push_back('{1'b0, 10'd8, 24'shFFFC00});
    items_to_send.push_back('{1'b1, 10'd512, 24'sh7FFFFF});
    wait_drained();

    // zero spreads, relax above one, negative slopes, zero heat base
    write_reg(REG_SOLID_SPR, 32'd0);
    write_reg(REG_LIQUID_SPR, 32'd0);
    write_reg(REG_RELAX, 32'h1FFFF);
    write_reg(REG_COND_SLOPE, 32'h1000000);
    write_reg(REG_HEAT_BASE, 32'd0);
    write_reg(REG_HEAT_SLOPE, 32'h800000);
    items_to_send.push_back('{1'b0, 10'd1, 24'sh000000});
    items_to_send.push_back('{1'b0, 10'd2, 24'sh000001});
    items_to_send.push_back('{1'b1, 10'd2, 24'sh800000});
    items_to_send.push_back('{1'b1, 10'd1, 24'sh7FFFFF});
    items_to_send.push_back('{1'b1, 10'd3, 24'sh000002});
    wait_drained();

    // maximum spreads and slopes, melt extremes
    write_reg(REG_SOLID_SPR, 32'h7FFFFF);
    write_reg(REG_LIQUID_SPR, 32'h7FFFFF);
    write_reg(REG_RELAX, 32'd0);
    write_reg(REG_COND_BASE, 32'hFFFFFF);
    write_reg(REG_COND_SLOPE, 32'h0FFFFFF);
    write_reg(REG_HEAT_BASE, 32'd1);
    write_reg(REG_HEAT_SLOPE, 32'h7FFFFF);
    write_reg(REG_MELT_MID, 32'h800000);
    items_to_send.push_back('{1'b0, 10'd4, 24'sh800000});
    items_to_send.push_back('{1'b1, 10'd4, 24'sh7FFFFF});
    items_to_send.push_back('{1'b0, 10'd9, 24'sh000000});
    wait_drained();
    write_reg(REG_MELT_MID, 32'h7FFFFF);
    items_to_send.push_back('{1'b0, 10'd10, 24'sh7FFFFF});
    items_to_send.push_back('{1'b0, 10'd11, 24'sh800000});
    items_to_send.push_back('{1'b1, 10'd11, 24'sh000000});
    wait_drained();

    // random phases, idling varied, long hold-off falls in one of these
    for (int ph = 0; ph < 7; ph++) begin
      random_config();
      gap_pct = (ph % 3 == 2) ? 0 : $urandom_range(5, 30);
      stall_pct = (ph % 3 == 1) ? 0 : $urandom_range(5, 30);
      queue_random(230);
      wait_drained();
    end

    // closing phase with no idling
    random_config();
    gap_pct = 0;
    stall_pct = 0;
    queue_random(200);
    wait_drained();

    if (!errors && props_due.size() == 0) begin
      $display("PASS pcm_liquid_fraction_update");
    end else begin
      $display("FAIL pcm_liquid_fraction_update");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pcmlf_pkg.sv
rtl/pcmlf_ram.sv
rtl/pcmlf_div.sv
rtl/pcm_liquid_fraction_update.sv
tb/pcm_liquid_fraction_update_tb.sv
